@@ rtl/dfar_pkg.sv @@
// shared types, constants and helpers of the dns fixed-answer responder
// used by dfar_front, dfar_fifo, dfar_back and dns_fixed_answer_responder
`default_nettype none

package dfar_pkg;

    localparam int MAX_QUERY_BYTES = 255;
    localparam int HEAD_BYTES      = 13;
    localparam int ANSWER_BYTES    = 16;
    localparam int MIN_QUERY_BYTES = 3;
    localparam int QUEUE_DEPTH     = 4;

    localparam int CNT_W  = $clog2(MAX_QUERY_BYTES + 1);
    localparam int HIDX_W = $clog2(HEAD_BYTES);
    localparam int LEN_W  = $clog2(HEAD_BYTES + 1);
    localparam int ANS_W  = $clog2(ANSWER_BYTES);
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  RESPONSE_BIT     = 8'h80;
    localparam logic [31:0] DEFAULT_IP       = 32'h0A0B0C0D;
    localparam int          FLAGS_IDX        = 2;
    localparam int          ANCOUNT_LO_IDX   = 7;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_PASS,
        CMD_HEAD
    } cmd_op_t;

    typedef enum logic {
        PH_BODY,
        PH_ANSWER
    } phase_t;

    // one queue entry: body part, then the answer record when answer is set
    typedef struct packed {
        cmd_op_t                      op;
        logic [7:0]                   data;
        logic [LEN_W-1:0]             len;
        logic                         modify;
        logic                         answer;
        logic [HEAD_BYTES-1:0][7:0]   head;
    } cmd_t;

    function automatic logic [7:0] answer_byte(input logic [ANS_W-1:0] idx,
                                               input logic [31:0] ip);
        logic [7:0] v;
        v = 8'h00;
        case (idx)
            4'd0:    v = 8'hC0;
            4'd1:    v = 8'h0C;
            4'd3:    v = 8'h01;
            4'd5:    v = 8'h01;
            4'd11:   v = 8'h04;
            4'd12:   v = ip[31:24];
            4'd13:   v = ip[23:16];
            4'd14:   v = ip[15:8];
            4'd15:   v = ip[7:0];
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/dfar_front.sv @@
// front end: counts query bytes, keeps the header bytes and classifies each byte
// into one queue command; depends on dfar_pkg
`default_nettype none

module dfar_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    output logic               in_ready,
    input  wire logic          q_full,
    output logic               q_push,
    output dfar_pkg::cmd_t     q_data
);

    logic [dfar_pkg::CNT_W-1:0]                     count_reg, count_next;
    logic                                           dropping_reg, dropping_next;
    logic [dfar_pkg::HEAD_BYTES-1:0][7:0]           head_reg;
    logic [dfar_pkg::HEAD_BYTES-1:0][7:0]           snap;
    logic                                           accept;
    logic                                           active;
    logic                                           drop_now;
    logic                                           drop_eff;
    logic                                           head_wr;
    logic [dfar_pkg::CNT_W-1:0]                     new_count;
    dfar_pkg::cmd_t                                 cmd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        active   = !dropping_reg && (count_reg < dfar_pkg::CNT_W'(dfar_pkg::MAX_QUERY_BYTES));
        head_wr  = active && (count_reg < dfar_pkg::CNT_W'(dfar_pkg::HEAD_BYTES));
        drop_now = active && (count_reg == dfar_pkg::CNT_W'(dfar_pkg::FLAGS_IDX))
                   && ((in_byte & dfar_pkg::RESPONSE_BIT) != 8'h00);
        drop_eff = dropping_reg || drop_now;
        new_count = active ? count_reg + 1'b1 : count_reg;

        // header with the current byte merged in
        for (int i = 0; i < dfar_pkg::HEAD_BYTES; i++)
        begin
            snap[i] = (head_wr && count_reg == dfar_pkg::CNT_W'(i)) ? in_byte : head_reg[i];
        end

        cmd.op     = dfar_pkg::CMD_NONE;
        cmd.data   = in_byte;
        cmd.len    = dfar_pkg::LEN_W'(dfar_pkg::HEAD_BYTES);
        cmd.modify = 1'b1;
        cmd.answer = 1'b0;
        cmd.head   = snap;

        if (active && !drop_now)
        begin
            if (count_reg == dfar_pkg::CNT_W'(dfar_pkg::HEAD_BYTES - 1))
            begin
                cmd.op = dfar_pkg::CMD_HEAD;
            end
            else if (count_reg >= dfar_pkg::CNT_W'(dfar_pkg::HEAD_BYTES))
            begin
                cmd.op = dfar_pkg::CMD_PASS;
            end
        end

        if (in_last && !drop_eff
            && new_count >= dfar_pkg::CNT_W'(dfar_pkg::MIN_QUERY_BYTES))
        begin
            cmd.answer = 1'b1;
            // short query: the whole held header goes out unchanged
            if (new_count < dfar_pkg::CNT_W'(dfar_pkg::HEAD_BYTES))
            begin
                cmd.op     = dfar_pkg::CMD_HEAD;
                cmd.len    = new_count[dfar_pkg::LEN_W-1:0];
                cmd.modify = 1'b0;
            end
        end

        q_push = accept && (cmd.op != dfar_pkg::CMD_NONE || cmd.answer);
        q_data = cmd;

        count_next    = count_reg;
        dropping_next = dropping_reg;
        if (accept)
        begin
            count_next    = in_last ? '0 : new_count;
            dropping_next = in_last ? 1'b0 : drop_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            dropping_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            dropping_reg <= dropping_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && head_wr)
        begin
            head_reg[count_reg[dfar_pkg::HIDX_W-1:0]] <= in_byte;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dfar_fifo.sv @@
// short command queue between the front end and the reply sequencer
// depends on dfar_pkg for the entry type and depth
`default_nettype none

module dfar_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire dfar_pkg::cmd_t  push_data,
    output logic                 full,
    input  wire logic            pop,
    output dfar_pkg::cmd_t       head_data,
    output logic                 empty
);

    dfar_pkg::cmd_t                  mem_reg [dfar_pkg::QUEUE_DEPTH];
    logic [dfar_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [dfar_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [dfar_pkg::QCNT_W-1:0]     fill_reg, fill_next;
    logic                            do_push;
    logic                            do_pop;

    assign full      = (fill_reg == dfar_pkg::QCNT_W'(dfar_pkg::QUEUE_DEPTH));
    assign empty     = (fill_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == dfar_pkg::QPTR_W'(dfar_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == dfar_pkg::QPTR_W'(dfar_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dfar_back.sv @@
// reply sequencer: walks the command at the queue head and drives the
// registered output byte stream; depends on dfar_pkg
`default_nettype none

module dfar_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dfar_pkg::cmd_t  cmd,
    input  wire logic            q_empty,
    output logic                 q_pop,
    input  wire logic [31:0]     answer_ip,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [7:0]           out_byte,
    output logic                 out_last
);

    dfar_pkg::phase_t            phase_reg, phase_next;
    logic [dfar_pkg::ANS_W-1:0]  cnt_reg, cnt_next;
    logic                        valid_reg, valid_next;
    logic [7:0]                  byte_reg, byte_next;
    logic                        last_reg, last_next;
    logic                        advance;
    logic                        emit;
    dfar_pkg::phase_t            phase_eff;
    logic [7:0]                  hb;

    assign advance   = !valid_reg || out_ready;
    assign emit      = advance && !q_empty;
    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        valid_next = out_ready ? 1'b0 : valid_reg;

        // a command with no body starts straight in the answer record
        phase_eff = (cmd.op == dfar_pkg::CMD_NONE) ? dfar_pkg::PH_ANSWER : phase_reg;

        hb = cmd.head[cnt_reg[dfar_pkg::HIDX_W-1:0]];
        if (cmd.modify && cnt_reg == dfar_pkg::ANS_W'(dfar_pkg::FLAGS_IDX))
        begin
            hb = hb | dfar_pkg::RESPONSE_BIT;
        end
        if (cmd.modify && cnt_reg == dfar_pkg::ANS_W'(dfar_pkg::ANCOUNT_LO_IDX))
        begin
            hb = hb + 8'd1;
        end

        if (emit)
        begin
            valid_next = 1'b1;
            last_next  = 1'b0;
            case (phase_eff)
                dfar_pkg::PH_BODY:
                begin
                    if (cmd.op == dfar_pkg::CMD_PASS)
                    begin
                        byte_next = cmd.data;
                        cnt_next  = '0;
                        if (cmd.answer)
                        begin
                            phase_next = dfar_pkg::PH_ANSWER;
                        end
                        else
                        begin
                            q_pop = 1'b1;
                        end
                    end
                    else
                    begin
                        byte_next = hb;
                        if (cnt_reg == dfar_pkg::ANS_W'(cmd.len - 1'b1))
                        begin
                            cnt_next = '0;
                            if (cmd.answer)
                            begin
                                phase_next = dfar_pkg::PH_ANSWER;
                            end
                            else
                            begin
                                q_pop = 1'b1;
                            end
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end
                dfar_pkg::PH_ANSWER:
                begin
                    byte_next = dfar_pkg::answer_byte(cnt_reg, answer_ip);
                    if (cnt_reg == dfar_pkg::ANS_W'(dfar_pkg::ANSWER_BYTES - 1))
                    begin
                        last_next  = 1'b1;
                        cnt_next   = '0;
                        phase_next = dfar_pkg::PH_BODY;
                        q_pop      = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = dfar_pkg::PH_BODY;
                    cnt_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dfar_pkg::PH_BODY;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    // a command only leaves the queue once its last byte is loaded
    a_pop_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> emit)
        else $error("queue pop without an emitted byte");

    // mid-answer the command must still sit at the queue head
    a_answer_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == dfar_pkg::PH_ANSWER || cnt_reg != '0) |-> !q_empty)
        else $error("sequencer mid-command with an empty queue");

    // reply ends only through the final answer byte
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last_next) |-> (q_pop && phase_next == dfar_pkg::PH_BODY))
        else $error("last byte flagged outside the end of an answer record");

endmodule

`default_nettype wire

@@ rtl/dns_fixed_answer_responder.sv @@
// top level of the dns fixed-answer responder: answer address register,
// front end, command queue and reply sequencer; depends on dfar_pkg and submodules
//
//  channel  dir  handshake              payload
//  s_axis   in   tvalid / tready        tdata = query_byte, tlast = query_last
//  m_axis   out  tvalid / tready        tdata = reply_byte, tlast = reply_last
//  cfg      in   cfg_valid / cfg_ready  cfg_data = answer_ip (32 bits)
//
// query bytes are taken one per cycle while the 4-entry command queue has room
// bytes 1 to 12 give no output unless last; byte 13 releases a 13-byte header
// burst, later bytes pass one per cycle; the last byte adds a 16-byte answer
// record; the sequencer emits one reply byte per cycle when not stalled, through a
// registered output, so an answered query of n bytes yields min(n,255)+16 reply
// bytes; reset is asynchronous; no clearing pass, the block is ready after reset
`default_nettype none

module dns_fixed_answer_responder (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // [7:0] query_byte
    input  wire logic          s_axis_tlast,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // [7:0] reply_byte
    output logic               m_axis_tlast,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [31:0]   cfg_data        // [31:0] answer_ip
);

    logic [31:0]       answer_ip_reg, answer_ip_next;
    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_empty;
    dfar_pkg::cmd_t    push_cmd;
    dfar_pkg::cmd_t    head_cmd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        answer_ip_next = answer_ip_reg;
        if (cfg_valid && cfg_ready)
        begin
            answer_ip_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answer_ip_reg <= dfar_pkg::DEFAULT_IP;
        end
        else
        begin
            answer_ip_reg <= answer_ip_next;
        end
    end

    dfar_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_cmd)
    );

    dfar_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .head_data (head_cmd),
        .empty     (q_empty)
    );

    dfar_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .answer_ip (answer_ip_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ test/tb_dns_fixed_answer_responder.sv @@
// self-checking testbench for dns_fixed_answer_responder: streams dns queries,
// predicts every reply byte and compares each m_axis transaction in order
// depends on rtl/dfar_pkg.sv and rtl/dns_fixed_answer_responder.sv
`timescale 1ns / 1ps

module tb_dns_fixed_answer_responder;

    localparam int NA = -1;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [0:11][7:0] ANSWER_PREFIX = {
        8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } reply_t;

    typedef struct packed {
        logic [7:0]        data;
        logic              last;
        logic signed [7:0] n_out;   // reply bytes this byte releases, NA if not obvious
    } query_row_t;

    localparam query_row_t DIRECTED [23] = '{
        // two-byte query is too short
        '{8'h00, 1'b0, 0}, '{8'hFF, 1'b1, 0},
        // shortest query that answers
        '{8'hFF, 1'b0, 0}, '{8'h00, 1'b0, 0}, '{8'h7F, 1'b1, 19},
        // flags byte already marked as a response
        '{8'h12, 1'b0, 0}, '{8'h34, 1'b0, 0}, '{8'h80, 1'b0, 0}, '{8'h55, 1'b1, 0},
        // lone byte
        '{8'hAA, 1'b1, 0},
        // full header, answer count low byte wraps from ff
        '{8'h01, 1'b0, 0}, '{8'h02, 1'b0, 0}, '{8'h00, 1'b0, 0}, '{8'hAB, 1'b0, 0},
        '{8'h00, 1'b0, 0}, '{8'h01, 1'b0, 0}, '{8'h00, 1'b0, 0}, '{8'hFF, 1'b0, 0},
        '{8'h00, 1'b0, 0}, '{8'h00, 1'b0, 0}, '{8'h55, 1'b0, 0}, '{8'hAA, 1'b0, 0},
        '{8'hFF, 1'b1, 29}
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    // responder state as the testbench sees it
    logic [31:0] ip_now;
    logic [7:0]  header_copy [dfar_pkg::HEAD_BYTES];
    int          bytes_seen;
    logic        ignoring;

    reply_t reply_due [$];
    int     errors;
    logic   quiet;      // no gaps on either side while set

    dns_fixed_answer_responder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic queue_reply(input logic [7:0] data, input logic last, inout int made);
        reply_due.push_back('{data: data, last: last});
        made++;
    endtask

    task automatic queue_header(input int len, input logic modify, inout int made);
        logic [7:0] v;
        for (int i = 0; i < len && i < dfar_pkg::HEAD_BYTES; i++)
        begin
            v = header_copy[i];
            if (modify && i == dfar_pkg::FLAGS_IDX)
                v = v | dfar_pkg::RESPONSE_BIT;
            if (modify && i == dfar_pkg::ANCOUNT_LO_IDX)
                v = v + 8'd1;
            queue_reply(v, 1'b0, made);
        end
    endtask

    // works out the reply bytes that one accepted query byte releases
    task automatic take_query_byte(input logic [7:0] b, input logic last, output int made);
        int idx;
        made = 0;
        if (!ignoring && bytes_seen < dfar_pkg::MAX_QUERY_BYTES)
        begin
            idx = bytes_seen;
            if (idx < dfar_pkg::HEAD_BYTES)
                header_copy[idx] = b;
            if (idx == dfar_pkg::FLAGS_IDX && (b & dfar_pkg::RESPONSE_BIT) != 0)
                ignoring = 1'b1;
            bytes_seen = idx + 1;
            if (!ignoring)
            begin
                if (idx == dfar_pkg::HEAD_BYTES - 1)
                    queue_header(dfar_pkg::HEAD_BYTES, 1'b1, made);
                else if (idx >= dfar_pkg::HEAD_BYTES)
                    queue_reply(b, 1'b0, made);
            end
        end
        if (last)
        begin
            if (!ignoring && bytes_seen >= dfar_pkg::MIN_QUERY_BYTES)
            begin
                if (bytes_seen < dfar_pkg::HEAD_BYTES)
                    queue_header(bytes_seen, 1'b0, made);
                for (int i = 0; i < 12; i++)
                    queue_reply(ANSWER_PREFIX[i], 1'b0, made);
                queue_reply(ip_now[31:24], 1'b0, made);
                queue_reply(ip_now[23:16], 1'b0, made);
                queue_reply(ip_now[15:8], 1'b0, made);
                queue_reply(ip_now[7:0], 1'b1, made);
            end
            bytes_seen = 0;
            ignoring   = 1'b0;
        end
    endtask

    // called at a falling edge, returns at a falling edge with tvalid still high
    task automatic send_byte(input logic [7:0] b, input logic last, output int made);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        take_query_byte(b, last, made);
        @(negedge clk);
    endtask

    task automatic send_query(input int len, input logic as_response, inout int sent);
        logic [7:0] b;
        int         made;
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (i == dfar_pkg::FLAGS_IDX)
                b = as_response ? (b | dfar_pkg::RESPONSE_BIT) : (b & ~dfar_pkg::RESPONSE_BIT);
            if (i == dfar_pkg::ANCOUNT_LO_IDX && $urandom_range(0, 3) == 0)
                b = 8'hFF;
            send_byte(b, i == len - 1, made);
            sent++;
        end
    endtask

    // sender holds off until the reply stream has fully drained
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (reply_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_answer_ip(input logic [31:0] value);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        ip_now = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // reply checker
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (reply_due.size() == 0)
            begin
                $display("%0t: unexpected reply byte %02h last %0b",
                         $realtime, m_axis_tdata, m_axis_tlast);
                errors++;
            end
            else
            begin
                want = reply_due.pop_front();
                if (m_axis_tdata !== want.data)
                begin
                    $display("%0t: reply byte expected %02h actual %02h",
                             $realtime, want.data, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: reply last expected %0b actual %0b",
                             $realtime, want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // reply side back-pressure
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int made;
        int sent;
        int len;
        int r;
        errors        = 0;
        quiet         = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 32'h0;
        ip_now        = dfar_pkg::DEFAULT_IP;
        bytes_seen    = 0;
        ignoring      = 1'b0;
        for (int i = 0; i < dfar_pkg::HEAD_BYTES; i++)
            header_copy[i] = 8'h00;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part runs on the reset address
        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            send_byte(DIRECTED[i].data, DIRECTED[i].last, made);
            if (DIRECTED[i].n_out != NA && made != DIRECTED[i].n_out)
            begin
                $display("%0t: row %0d reply count expected %0d actual %0d",
                         $realtime, i, DIRECTED[i].n_out, made);
                errors++;
            end
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            case (phase)
                0: write_answer_ip(32'hFFFFFFFF);
                1: write_answer_ip(32'h00000000);
                default: write_answer_ip($urandom);
            endcase
            quiet = (phase == 1);
            sent  = 0;
            // one query past the length cap, it fills this phase's share
            if (phase == 2)
                send_query($urandom_range(dfar_pkg::MAX_QUERY_BYTES + 1,
                                          dfar_pkg::MAX_QUERY_BYTES + 3),
                           1'b0, sent);
            while (sent < 16)
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    len = $urandom_range(1, 2);
                else if (r < 60)
                    len = $urandom_range(3, 13);
                else if (r < 90)
                    len = $urandom_range(14, 24);
                else
                    len = $urandom_range(25, 60);
                send_query(len, $urandom_range(0, 99) < 15, sent);
            end
        end
        quiet = 1'b0;

        s_axis_tvalid = 1'b0;
        while (reply_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && reply_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
